>>> rtl/thermocouple_read_or_heater_simulation_top_defines.svh
// ----------------------------------------------------------------------------
// thermocouple read / heater simulation: assertion macros
// shared concurrent assertion forms, clocked on i_clk, off while in reset
// ----------------------------------------------------------------------------
`ifndef THERMOCOUPLE_READ_OR_HEATER_SIMULATION_TOP_DEFINES_SVH
`define THERMOCOUPLE_READ_OR_HEATER_SIMULATION_TOP_DEFINES_SVH

// same-cycle implication
`define TCRHS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tcrhs: same-cycle check failed");

// next-cycle implication
`define TCRHS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tcrhs: next-cycle check failed");

`endif

>>> rtl/tcrhs_pkg.sv
// ----------------------------------------------------------------------------
// tcrhs_pkg
// types, codes and constants shared by the thermocouple / plate model block
// ----------------------------------------------------------------------------
package tcrhs_pkg;

    // widths
    localparam int PLATE_W  = 25;
    localparam int MAG_W    = 28;
    localparam int PROD_W   = 60;
    localparam int QUOT_W   = 29;
    localparam int REM_W    = 34;
    localparam int TEMP_W   = 21;
    localparam int POWER_W  = 15;

    // plate model constants, Q16 degrees C
    localparam logic [PLATE_W-1:0] AMBIENT_Q16   = 25'd1310720;
    localparam logic [PLATE_W-1:0] PLATE_MIN_Q16 = 25'd983040;
    localparam logic [PLATE_W-1:0] PLATE_MAX_Q16 = 25'd22937600;
    localparam logic [POWER_W-1:0] POWER_MAX     = 15'd25600;

    // heat capacity times microseconds per second, and its scaled reciprocal
    localparam logic [31:0] DIVISOR    = 32'd2200000000;
    localparam logic [32:0] DIVISOR_X2 = 33'd4400000000;
    localparam logic [31:0] RECIP_M    = 32'd4192441834;

    // output limits, 1/256 degree C
    localparam logic signed [TEMP_W-1:0] OUT_MIN = -21'sd12800;
    localparam logic signed [TEMP_W-1:0] OUT_MAX = 21'sd128000;

    // register indexes
    localparam logic [0:0] CFG_SIM_EN = 1'b0;
    localparam logic [0:0] CFG_OFFSET = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_SPI_ERR   = 2'd1,
        STATUS_SHORT_GND = 2'd2,
        STATUS_SHORT_VCC = 2'd3
    } t_status;

    typedef struct packed {
        logic signed [15:0] heating_power;
        logic [31:0]        elapsed_us;
        logic [31:0]        raw_word;
        logic               spi_ok;
    } t_in_item;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temperature;
        t_status                  status;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROD,
        ST_RECIP,
        ST_BACK,
        ST_CORR,
        ST_UPD,
        ST_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic prime;
        logic mul_prod;
        logic mul_recip;
        logic mul_back;
        logic correct;
        logic update;
        logic load_out;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic sim_en;
        logic primed;
    } t_dp_stat;

endpackage

>>> rtl/tcrhs_dp.sv
// ----------------------------------------------------------------------------
// tcrhs_dp
// datapath: config registers, converter word decode, plate model arithmetic
// and the output payload register
// ----------------------------------------------------------------------------
module tcrhs_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [0:0]           i_cfg_idx,
    input  logic [15:0]          i_cfg_data,
    input  tcrhs_pkg::t_in_item  i_item,
    input  tcrhs_pkg::t_dp_cmd   i_cmd,
    output tcrhs_pkg::t_dp_stat  o_stat,
    output tcrhs_pkg::t_out_item o_result
);

    // architectural state
    logic                                r_sim_en;
    logic signed [15:0]                  r_offset;
    logic [tcrhs_pkg::PLATE_W-1:0]       r_plate;
    logic                                r_primed;

    // per-item working registers
    logic [31:0]                         r_raw;
    logic                                r_spi_ok;
    logic [31:0]                         r_elapsed;
    logic [tcrhs_pkg::MAG_W-1:0]         r_net_mag;
    logic                                r_net_neg;
    logic [tcrhs_pkg::PROD_W-1:0]        r_prod;
    logic [tcrhs_pkg::QUOT_W-1:0]        r_q_est;
    logic [tcrhs_pkg::REM_W-1:0]         r_back;
    logic [tcrhs_pkg::QUOT_W-1:0]        r_q;
    tcrhs_pkg::t_out_item                r_out;

    logic [tcrhs_pkg::POWER_W-1:0]       w_power;
    logic [tcrhs_pkg::MAG_W-1:0]         w_heat;
    logic signed [25:0]                  w_dt;
    logic signed [28:0]                  w_loss;
    logic signed [29:0]                  w_net;
    logic [29:0]                         w_net_abs;
    logic [tcrhs_pkg::PROD_W-1:0]        w_prod;
    logic [60:0]                         w_recip;
    logic [60:0]                         w_back;
    logic [tcrhs_pkg::REM_W-1:0]         w_rem;
    logic [1:0]                          w_inc;
    logic signed [30:0]                  w_change;
    logic signed [30:0]                  w_sum;
    logic [tcrhs_pkg::PLATE_W-1:0]       w_plate_next;
    logic signed [tcrhs_pkg::TEMP_W-1:0] w_sim_sum;
    logic signed [tcrhs_pkg::TEMP_W-1:0] w_sim_temp;
    logic signed [tcrhs_pkg::TEMP_W-1:0] w_real_temp;
    tcrhs_pkg::t_out_item                w_out;

    // heating power clamp and net heat flow in Q16 W
    always_comb begin
        if (i_item.heating_power[15]) begin
            w_power = '0;
        end else if (i_item.heating_power[14:0] > tcrhs_pkg::POWER_MAX) begin
            w_power = tcrhs_pkg::POWER_MAX;
        end else begin
            w_power = i_item.heating_power[14:0];
        end
        // p * 5632 = p * (4096 + 1024 + 512)
        w_heat = ({13'b0, w_power} << 12) + ({13'b0, w_power} << 10)
               + ({13'b0, w_power} << 9);
        w_dt   = $signed({1'b0, r_plate}) - $signed({1'b0, tcrhs_pkg::AMBIENT_Q16});
        w_loss = $signed({w_dt[25], w_dt, 2'b00}) + $signed({{3{w_dt[25]}}, w_dt});
        w_net  = $signed({2'b00, w_heat}) - $signed({w_loss[28], w_loss});
        w_net_abs = w_net[29] ? 30'(-w_net) : 30'(w_net);
    end

    // long product, reciprocal estimate, back-multiply and correction
    always_comb begin
        w_prod  = {32'b0, r_net_mag} * {28'b0, r_elapsed};
        w_recip = {32'b0, r_prod[tcrhs_pkg::PROD_W-1:31]} * {29'b0, tcrhs_pkg::RECIP_M};
        w_back  = {32'b0, r_q_est} * {29'b0, tcrhs_pkg::DIVISOR};
        w_rem   = r_prod[tcrhs_pkg::REM_W-1:0] - r_back;
        if (w_rem >= {1'b0, tcrhs_pkg::DIVISOR_X2}) begin
            w_inc = 2'd2;
        end else if (w_rem >= {2'b00, tcrhs_pkg::DIVISOR}) begin
            w_inc = 2'd1;
        end else begin
            w_inc = 2'd0;
        end
    end

    // plate update with clamp to 15..350 C
    always_comb begin
        w_change = r_net_neg ? -$signed({2'b00, r_q}) : $signed({2'b00, r_q});
        w_sum    = $signed({6'b0, r_plate}) + w_change;
        if (w_sum < $signed({6'b0, tcrhs_pkg::PLATE_MIN_Q16})) begin
            w_plate_next = tcrhs_pkg::PLATE_MIN_Q16;
        end else if (w_sum > $signed({6'b0, tcrhs_pkg::PLATE_MAX_Q16})) begin
            w_plate_next = tcrhs_pkg::PLATE_MAX_Q16;
        end else begin
            w_plate_next = w_sum[tcrhs_pkg::PLATE_W-1:0];
        end
    end

    // result forming for both modes
    always_comb begin
        w_sim_sum = $signed({4'b0, r_plate[tcrhs_pkg::PLATE_W-1:8]})
                  + $signed({{5{r_offset[15]}}, r_offset});
        if (w_sim_sum < tcrhs_pkg::OUT_MIN) begin
            w_sim_temp = tcrhs_pkg::OUT_MIN;
        end else if (w_sim_sum > tcrhs_pkg::OUT_MAX) begin
            w_sim_temp = tcrhs_pkg::OUT_MAX;
        end else begin
            w_sim_temp = w_sim_sum;
        end
        w_real_temp = $signed({r_raw[31], r_raw[31:18], 6'b0})
                    + $signed({{5{r_offset[15]}}, r_offset});

        w_out.temperature = '0;
        w_out.status      = tcrhs_pkg::STATUS_OK;
        if (r_sim_en) begin
            w_out.temperature = w_sim_temp;
        end else if (!r_spi_ok) begin
            w_out.status = tcrhs_pkg::STATUS_SPI_ERR;
        end else if (r_raw[0]) begin
            w_out.status = tcrhs_pkg::STATUS_SHORT_GND;
        end else if (r_raw[1]) begin
            w_out.status = tcrhs_pkg::STATUS_SHORT_VCC;
        end else begin
            w_out.temperature = w_real_temp;
        end
    end

    // config and model state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sim_en <= 1'b0;
            r_offset <= '0;
            r_plate  <= tcrhs_pkg::AMBIENT_Q16;
            r_primed <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    tcrhs_pkg::CFG_SIM_EN: r_sim_en <= i_cfg_data[0];
                    tcrhs_pkg::CFG_OFFSET: r_offset <= $signed(i_cfg_data);
                    default: ;
                endcase
            end
            if (i_cmd.prime) begin
                r_primed <= 1'b1;
            end
            if (i_cmd.update) begin
                r_plate <= w_plate_next;
            end
        end
    end

    // working registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_raw     <= i_item.raw_word;
            r_spi_ok  <= i_item.spi_ok;
            r_elapsed <= i_item.elapsed_us;
            r_net_mag <= w_net_abs[tcrhs_pkg::MAG_W-1:0];
            r_net_neg <= w_net[29];
        end
        if (i_cmd.mul_prod) begin
            r_prod <= w_prod;
        end
        if (i_cmd.mul_recip) begin
            r_q_est <= w_recip[60:32];
        end
        if (i_cmd.mul_back) begin
            r_back <= w_back[tcrhs_pkg::REM_W-1:0];
        end
        if (i_cmd.correct) begin
            r_q <= r_q_est + {27'b0, w_inc};
        end
        if (i_cmd.load_out) begin
            r_out <= w_out;
        end
    end

    assign o_stat.sim_en = r_sim_en;
    assign o_stat.primed = r_primed;
    assign o_result      = r_out;

endmodule

>>> rtl/tcrhs_ctrl.sv
// ----------------------------------------------------------------------------
// tcrhs_ctrl
// controller: sequences the model arithmetic and owns both handshakes
// ----------------------------------------------------------------------------
module tcrhs_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  tcrhs_pkg::t_dp_stat i_stat,
    output tcrhs_pkg::t_dp_cmd  o_cmd
);

    tcrhs_pkg::t_state r_state;
    tcrhs_pkg::t_state n_state;
    logic              r_out_valid;
    logic              n_out_valid;

    // state and output valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tcrhs_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            tcrhs_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    o_cmd.prime   = i_stat.sim_en && !i_stat.primed;
                    if (i_stat.sim_en && i_stat.primed) begin
                        n_state = tcrhs_pkg::ST_PROD;
                    end else begin
                        n_state = tcrhs_pkg::ST_OUT;
                    end
                end
            end
            tcrhs_pkg::ST_PROD: begin
                o_cmd.mul_prod = 1'b1;
                n_state        = tcrhs_pkg::ST_RECIP;
            end
            tcrhs_pkg::ST_RECIP: begin
                o_cmd.mul_recip = 1'b1;
                n_state         = tcrhs_pkg::ST_BACK;
            end
            tcrhs_pkg::ST_BACK: begin
                o_cmd.mul_back = 1'b1;
                n_state        = tcrhs_pkg::ST_CORR;
            end
            tcrhs_pkg::ST_CORR: begin
                o_cmd.correct = 1'b1;
                n_state       = tcrhs_pkg::ST_UPD;
            end
            tcrhs_pkg::ST_UPD: begin
                o_cmd.update = 1'b1;
                n_state      = tcrhs_pkg::ST_OUT;
            end
            tcrhs_pkg::ST_OUT: begin
                // wait for the output register to free up
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = tcrhs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tcrhs_pkg::ST_IDLE;
            end
        endcase

        // output valid: set on load, cleared when taken
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_in_ready  = (r_state == tcrhs_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

>>> rtl/thermocouple_read_or_heater_simulation_top.sv
// ----------------------------------------------------------------------------
// thermocouple_read_or_heater_simulation_top
// Input channel i_valid/o_ready carries one read item (heater power, elapsed
// time, converter word, serial ok). Output channel o_valid/i_ready carries
// one item per read: temperature in 1/256 C and a status code.
// Config: i_cfg_we with i_cfg_idx 0 = simulation enable, 1 = calibration
// offset; the user must see that these are written only while no read is
// in flight, as the block itself does not enforce it. In converter mode and
// on the first simulated read an accepted item goes straight to the output
// load; a simulated read with a plate update first runs the chain of three
// registered multiplies (product, reciprocal estimate, back-multiply),
// correction and plate update. One item is worked on at a time: a new item
// is taken only once the last one has been loaded into the output register.
// The output register holds a result while the receiver stalls; the next
// item is still taken and worked, and waits in its final step until the
// output register is free.
// Reset: plate at 20 C, model not primed, converter mode, zero offset,
// no result pending.
// ----------------------------------------------------------------------------
module thermocouple_read_or_heater_simulation_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  tcrhs_pkg::t_in_item  i_item,
    output logic                 o_valid,
    input  logic                 i_ready,
    output tcrhs_pkg::t_out_item o_result,
    input  logic                 i_cfg_we,
    input  logic [0:0]           i_cfg_idx,
    input  logic [15:0]          i_cfg_data
);

    tcrhs_pkg::t_dp_cmd  w_cmd;
    tcrhs_pkg::t_dp_stat w_stat;

    // sequencer
    tcrhs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // arithmetic and state
    tcrhs_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_item),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_result   (o_result)
    );

endmodule

>>> rtl/tcrhs_checker.sv
// ----------------------------------------------------------------------------
// tcrhs_checker
// port-level checks on the top level, attached by bind
// ----------------------------------------------------------------------------
`include "thermocouple_read_or_heater_simulation_top_defines.svh"

module tcrhs_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 o_ready,
    input logic                 o_valid,
    input logic                 i_ready,
    input tcrhs_pkg::t_out_item o_result
);

    // a stalled result stays put
    `TCRHS_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_result))

    // a fault reading carries zero temperature
    `TCRHS_ASSERT_IMPL(a_fault_zero, o_valid && (o_result.status != tcrhs_pkg::STATUS_OK), o_result.temperature == 21'sd0)

    // one item in work at a time
    `TCRHS_ASSERT_NEXT(a_one_in_work, i_valid && o_ready, !o_ready)

    // a new result only appears while an item is in work
    `TCRHS_ASSERT_IMPL(a_result_from_item, $rose(o_valid), !$past(o_ready))

endmodule

bind thermocouple_read_or_heater_simulation_top tcrhs_checker u_tcrhs_checker (.*);
